FILE: sv/tilt_compensated_range_unit_macros.svh
// Assertion macros shared by the checker of the tilt compensated range unit.
`ifndef TILT_COMPENSATED_RANGE_UNIT_MACROS_SVH
`define TILT_COMPENSATED_RANGE_UNIT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define TCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tilt range unit: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define TCR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tilt range unit: same-cycle check failed");

// The consequent must hold in the cycle after reset is seen.
`define TCR_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("tilt range unit: reset check failed");

`endif

FILE: sv/tcr_pkg.sv
// Types, constants and the arctangent table of the tilt compensated range unit.
package tcr_pkg;

    localparam int DW      = 36;
    localparam int SQW     = 58;
    localparam int ROOTW   = 29;
    localparam int ITW     = 5;
    localparam int MAX_ITER = 24;

    localparam logic signed [DW-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [DW-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [DW-1:0] CORDIC_GAIN = 36'sh026DD3B6A;

    typedef enum logic [3:0] {
        ST_IDLE, ST_QMUL, ST_QFORM, ST_SQMUL, ST_SQSTART, ST_PSQRT, ST_PCORD,
        ST_RCORD, ST_CHECK, ST_TMUL, ST_TSQRT, ST_COS, ST_AMUL, ST_AOUT
    } t_state;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_req;

    function automatic logic signed [DW-1:0] atan_at(input logic [ITW-1:0] idx);
        logic signed [DW-1:0] v;
        case (idx)
            5'd0:    v = 36'sh03243F6A8;
            5'd1:    v = 36'sh01DAC6705;
            5'd2:    v = 36'sh00FADBAFC;
            5'd3:    v = 36'sh007F56EA6;
            5'd4:    v = 36'sh003FEAB76;
            5'd5:    v = 36'sh001FFD55B;
            5'd6:    v = 36'sh000FFFAAA;
            5'd7:    v = 36'sh0007FFF55;
            5'd8:    v = 36'sh0003FFFEA;
            5'd9:    v = 36'sh0001FFFFD;
            5'd10:   v = 36'sh0000FFFFF;
            5'd11:   v = 36'sh00007FFFF;
            5'd12:   v = 36'sh00003FFFF;
            5'd13:   v = 36'sh00001FFFF;
            5'd14:   v = 36'sh00000FFFF;
            5'd15:   v = 36'sh000007FFF;
            5'd16:   v = 36'sh000003FFF;
            5'd17:   v = 36'sh000001FFF;
            5'd18:   v = 36'sh000000FFF;
            5'd19:   v = 36'sh0000007FF;
            5'd20:   v = 36'sh0000003FF;
            5'd21:   v = 36'sh0000001FF;
            5'd22:   v = 36'sh0000000FF;
            5'd23:   v = 36'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] to_q12(input logic signed [DW-1:0] z);
        logic signed [DW-1:0] t;
        logic signed [15:0]   r;
        t = (z + 36'sd131072) >>> 18;
        if (t > 36'sd32767) begin
            r = 16'sh7FFF;
        end else if (t < -36'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/tcr_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, in vectoring or rotation mode.
module tcr_cordic #(
    parameter int ITER = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcr_pkg::t_cordic_req              i_req,
    input  logic signed [tcr_pkg::DW-1:0]     i_x,
    input  logic signed [tcr_pkg::DW-1:0]     i_y,
    input  logic signed [tcr_pkg::DW-1:0]     i_z,
    output logic                              o_done,
    output logic signed [tcr_pkg::DW-1:0]     o_x,
    output logic signed [tcr_pkg::DW-1:0]     o_z
);
    localparam int N = (ITER > tcr_pkg::MAX_ITER) ? tcr_pkg::MAX_ITER : ITER;

    logic                          r_busy;
    logic                          r_done;
    logic                          r_vec;
    logic                          r_zero;
    logic [tcr_pkg::ITW-1:0]       r_i;
    logic signed [tcr_pkg::DW-1:0] r_x;
    logic signed [tcr_pkg::DW-1:0] r_y;
    logic signed [tcr_pkg::DW-1:0] r_z;
    logic signed [tcr_pkg::DW-1:0] xs;
    logic signed [tcr_pkg::DW-1:0] ys;
    logic signed [tcr_pkg::DW-1:0] at;
    logic                          dir;

    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign at  = tcr_pkg::atan_at(r_i);
    assign dir = r_vec ? (r_y <= 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == tcr_pkg::ITW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vec  <= i_req.vectoring;
            r_zero <= i_req.vectoring && (i_x == 0) && (i_y == 0);
            if (i_req.vectoring && (i_x < 0)) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= (i_y >= 0) ? tcr_pkg::ANG_PI : -tcr_pkg::ANG_PI;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_req.vectoring ? '0 : i_z;
            end
        end else if (r_busy) begin
            if (dir) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_zero ? '0 : r_z;
endmodule

FILE: sv/tcr_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module tcr_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcr_pkg::SQW-1:0]      i_op,
    output logic                         o_done,
    output logic [tcr_pkg::ROOTW-1:0]    o_root
);
    logic                      r_busy;
    logic                      r_done;
    logic [tcr_pkg::SQW-1:0]   r_v;
    logic [tcr_pkg::SQW-1:0]   r_res;
    logic [tcr_pkg::SQW-1:0]   r_bit;
    logic [tcr_pkg::SQW-1:0]   trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == tcr_pkg::SQW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_op;
            r_res <= '0;
            r_bit <= tcr_pkg::SQW'(1) << (tcr_pkg::SQW - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[tcr_pkg::ROOTW-1:0];
endmodule

FILE: sv/tilt_compensated_range_unit.sv
// Top level of the tilt compensated range unit: sequencer, shared multiplier and state.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata: range_mm, quat_x, quat_y, quat_z, quat_w; tuser: action
//  m_axis    out  tdata: altitude_mm
//
// A range beat is worked through in order: tilt products, the isqrt, the cosine rotation
// and the altitude product. An orientation beat first adds its products, an isqrt and
// two vectoring passes for pitch and roll.
// Until both sample kinds are seen no result is made and the tilt steps are skipped.
// Reset is synchronous and clears the seen flags and the output valid flag.
// A finished result waits while an earlier one stalls on m_axis, and intake stays closed.
module tilt_compensated_range_unit #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int RANGE_BITS        = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // range_mm, quat_x, quat_y, quat_z, quat_w from the lowest bit up.
    input  logic [((RANGE_BITS+64+7)/8)*8-1:0] s_axis_tdata,
    // action.
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // altitude_mm.
    output logic [((RANGE_BITS+1+7)/8)*8-1:0]  m_axis_tdata
);
    localparam int OUTW = ((RANGE_BITS + 1 + 7) / 8) * 8;
    localparam int DW   = tcr_pkg::DW;

    tcr_pkg::t_state          r_state, n_state;
    logic [2:0]               r_cnt, n_cnt;
    logic                     r_oseen, r_rseen, r_ovalid;
    logic signed [RANGE_BITS:0] r_out;
    logic [RANGE_BITS-1:0]    r_range;
    logic signed [15:0]       r_qx, r_qy, r_qz, r_qw;
    logic signed [15:0]       r_roll, r_pitch;
    logic signed [31:0]       r_acc_s;
    logic signed [32:0]       r_acc_r, r_acc_q;
    logic signed [31:0]       r_sinp;
    logic signed [33:0]       r_m21, r_m22;
    logic [31:0]              r_sum;
    logic signed [31:0]       r_c;
    logic                     r_neg;
    logic signed [63:0]       r_prod;
    logic signed [31:0]       n_mul_a, n_mul_b;

    tcr_pkg::t_cordic_req     cd_req;
    logic signed [DW-1:0]     cd_x, cd_y, cd_z, cd_ox, cd_oz;
    logic                     cd_done;
    logic                     sq_start, sq_done;
    logic [tcr_pkg::SQW-1:0]  sq_op;
    logic [tcr_pkg::ROOTW-1:0] sq_root;

    logic                     in_acc;
    logic signed [32:0]       s2;
    logic signed [DW-1:0]     tilt;
    logic signed [63:0]       rnd;
    logic signed [33:0]       alt;
    logic signed [33:0]       lim;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s2     = 33'(r_acc_s) <<< 1;
    assign tilt   = DW'({sq_root[15:0], 18'b0});
    assign rnd    = r_prod + 64'sd536870912;
    assign alt    = rnd[63:30];
    assign lim    = (34'sd1 <<< RANGE_BITS) - 34'sd1;

    tcr_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cd_req),
        .i_x     (cd_x),
        .i_y     (cd_y),
        .i_z     (cd_z),
        .o_done  (cd_done),
        .o_x     (cd_ox),
        .o_z     (cd_oz)
    );

    tcr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_op    (sq_op),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcr_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_oseen  <= 1'b0;
            r_rseen  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (in_acc && !s_axis_tuser) begin
                r_rseen <= 1'b1;
            end
            if (r_state == tcr_pkg::ST_RCORD && cd_done) begin
                r_oseen <= 1'b1;
            end
            if (r_state == tcr_pkg::ST_AOUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_mul_a    = '0;
        n_mul_b    = '0;
        cd_req     = '0;
        cd_x       = '0;
        cd_y       = '0;
        cd_z       = '0;
        sq_start   = 1'b0;
        sq_op      = '0;
        case (r_state)
            tcr_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (in_acc) begin
                    n_state = s_axis_tuser ? tcr_pkg::ST_QMUL : tcr_pkg::ST_CHECK;
                end
            end
            tcr_pkg::ST_QMUL: begin
                case (r_cnt)
                    3'd0: begin n_mul_a = 32'(r_qw); n_mul_b = 32'(r_qy); end
                    3'd1: begin n_mul_a = 32'(r_qx); n_mul_b = 32'(r_qz); end
                    3'd2: begin n_mul_a = 32'(r_qw); n_mul_b = 32'(r_qx); end
                    3'd3: begin n_mul_a = 32'(r_qy); n_mul_b = 32'(r_qz); end
                    3'd4: begin n_mul_a = 32'(r_qx); n_mul_b = 32'(r_qx); end
                    3'd5: begin n_mul_a = 32'(r_qy); n_mul_b = 32'(r_qy); end
                    default: begin n_mul_a = '0; n_mul_b = '0; end
                endcase
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd6) begin
                    n_state = tcr_pkg::ST_QFORM;
                end
            end
            tcr_pkg::ST_QFORM: begin
                n_state = tcr_pkg::ST_SQMUL;
            end
            tcr_pkg::ST_SQMUL: begin
                n_mul_a = r_sinp;
                n_mul_b = r_sinp;
                n_state = tcr_pkg::ST_SQSTART;
            end
            tcr_pkg::ST_SQSTART: begin
                sq_start = 1'b1;
                sq_op    = tcr_pkg::SQW'((64'sd1 <<< 56) - r_prod);
                n_state  = tcr_pkg::ST_PSQRT;
            end
            tcr_pkg::ST_PSQRT: begin
                if (sq_done) begin
                    cd_req.start     = 1'b1;
                    cd_req.vectoring = 1'b1;
                    cd_x    = DW'({1'b0, sq_root});
                    cd_y    = DW'(r_sinp);
                    n_state = tcr_pkg::ST_PCORD;
                end
            end
            tcr_pkg::ST_PCORD: begin
                if (cd_done) begin
                    cd_req.start     = 1'b1;
                    cd_req.vectoring = 1'b1;
                    cd_x    = DW'(r_m22);
                    cd_y    = DW'(r_m21);
                    n_state = tcr_pkg::ST_RCORD;
                end
            end
            tcr_pkg::ST_RCORD: begin
                if (cd_done) begin
                    n_state = tcr_pkg::ST_CHECK;
                end
            end
            tcr_pkg::ST_CHECK: begin
                n_cnt   = '0;
                n_state = (r_oseen && r_rseen) ? tcr_pkg::ST_TMUL : tcr_pkg::ST_IDLE;
            end
            tcr_pkg::ST_TMUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd0) begin
                    n_mul_a = 32'(r_roll);
                    n_mul_b = 32'(r_roll);
                end else if (r_cnt == 3'd1) begin
                    n_mul_a = 32'(r_pitch);
                    n_mul_b = 32'(r_pitch);
                end else begin
                    sq_start = 1'b1;
                    sq_op    = tcr_pkg::SQW'(r_sum + r_prod[31:0]);
                    n_state  = tcr_pkg::ST_TSQRT;
                end
            end
            tcr_pkg::ST_TSQRT: begin
                if (sq_done) begin
                    cd_req.start     = 1'b1;
                    cd_req.vectoring = 1'b0;
                    cd_x    = tcr_pkg::CORDIC_GAIN;
                    cd_z    = (tilt > tcr_pkg::ANG_HALF_PI) ? (tcr_pkg::ANG_PI - tilt) : tilt;
                    n_state = tcr_pkg::ST_COS;
                end
            end
            tcr_pkg::ST_COS: begin
                if (cd_done) begin
                    n_state = tcr_pkg::ST_AMUL;
                end
            end
            tcr_pkg::ST_AMUL: begin
                n_mul_a = 32'(r_range);
                n_mul_b = r_c;
                n_state = tcr_pkg::ST_AOUT;
            end
            tcr_pkg::ST_AOUT: begin
                n_mul_a = 32'(r_range);
                n_mul_b = r_c;
                if (!r_ovalid || m_axis_tready) begin
                    n_state = tcr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(n_mul_a) * 64'(n_mul_b);
        if (in_acc) begin
            if (s_axis_tuser) begin
                r_qx <= s_axis_tdata[RANGE_BITS +: 16];
                r_qy <= s_axis_tdata[RANGE_BITS + 16 +: 16];
                r_qz <= s_axis_tdata[RANGE_BITS + 32 +: 16];
                r_qw <= s_axis_tdata[RANGE_BITS + 48 +: 16];
            end else begin
                r_range <= s_axis_tdata[RANGE_BITS-1:0];
            end
        end
        if (r_state == tcr_pkg::ST_QMUL) begin
            case (r_cnt)
                3'd1:    r_acc_s <= r_prod[31:0];
                3'd2:    r_acc_s <= r_acc_s - r_prod[31:0];
                3'd3:    r_acc_r <= r_prod[32:0];
                3'd4:    r_acc_r <= r_acc_r + r_prod[32:0];
                3'd5:    r_acc_q <= r_prod[32:0];
                3'd6:    r_acc_q <= r_acc_q + r_prod[32:0];
                default: r_acc_q <= r_acc_q;
            endcase
        end
        if (r_state == tcr_pkg::ST_QFORM) begin
            if (s2 > 33'sd268435456) begin
                r_sinp <= 32'sd268435456;
            end else if (s2 < -33'sd268435456) begin
                r_sinp <= -32'sd268435456;
            end else begin
                r_sinp <= s2[31:0];
            end
            r_m21 <= 34'(r_acc_r) <<< 1;
            r_m22 <= 34'sd268435456 - (34'(r_acc_q) <<< 1);
        end
        if (r_state == tcr_pkg::ST_PCORD && cd_done) begin
            r_pitch <= tcr_pkg::to_q12(cd_oz);
        end
        if (r_state == tcr_pkg::ST_RCORD && cd_done) begin
            r_roll <= tcr_pkg::to_q12(cd_oz);
        end
        if (r_state == tcr_pkg::ST_TMUL && r_cnt == 3'd1) begin
            r_sum <= r_prod[31:0];
        end
        if (r_state == tcr_pkg::ST_TSQRT && sq_done) begin
            r_neg <= (tilt > tcr_pkg::ANG_HALF_PI);
        end
        if (r_state == tcr_pkg::ST_COS && cd_done) begin
            r_c <= r_neg ? -cd_ox[31:0] : cd_ox[31:0];
        end
        if (r_state == tcr_pkg::ST_AOUT && (!r_ovalid || m_axis_tready)) begin
            if (alt > lim) begin
                r_out <= lim[RANGE_BITS:0];
            end else if (alt < -lim) begin
                r_out <= -lim[RANGE_BITS:0];
            end else begin
                r_out <= alt[RANGE_BITS:0];
            end
        end
    end

    assign s_axis_tready = (r_state == tcr_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUTW'(unsigned'(r_out));
endmodule

FILE: sv/tcr_checker.sv
// Port-level checker of the tilt compensated range unit and its bind.
`include "tilt_compensated_range_unit_macros.svh"

module tcr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    `TCR_ASSERT_RESET(a_reset_no_result, !m_axis_tvalid)
    `TCR_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TCR_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TCR_ASSERT_SAME(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready))
endmodule

bind tilt_compensated_range_unit tcr_checker u_tcr_checker (.*);

FILE: dv/tcr_checker.sv
// Checker that predicts and compares the altitude beats of the tilt compensated range unit.
module tcr_scoreboard #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int RANGE_BITS        = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [79:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    output int          o_errors,
    output int          o_pending
);
    localparam longint UNIT28 = 64'sd1 << 28;

    logic signed [15:0] roll_q12, pitch_q12;
    longint             held_range;
    bit                 have_orient, have_range;
    logic [RANGE_BITS:0] altitude_queue[$];
    int                 errors;

    assign o_errors  = errors;
    assign o_pending = altitude_queue.size();

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root64(longint v);
        longint res, bit_w;
        res = 0;
        bit_w = 64'sd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic int steps();
        return CORDIC_ITERATIONS > 24 ? 24 : CORDIC_ITERATIONS;
    endfunction

    function automatic longint arc_tab(int i);
        logic signed [35:0] v;
        case (i)
            0: v = 36'sh03243F6A8;  1: v = 36'sh01DAC6705;  2: v = 36'sh00FADBAFC;
            3: v = 36'sh007F56EA6;  4: v = 36'sh003FEAB76;  5: v = 36'sh001FFD55B;
            6: v = 36'sh000FFFAAA;  7: v = 36'sh0007FFF55;  8: v = 36'sh0003FFFEA;
            9: v = 36'sh0001FFFFD; 10: v = 36'sh0000FFFFF; 11: v = 36'sh00007FFFF;
            12: v = 36'sh00003FFFF; 13: v = 36'sh00001FFFF; 14: v = 36'sh00000FFFF;
            15: v = 36'sh000007FFF; 16: v = 36'sh000003FFF; 17: v = 36'sh000001FFF;
            18: v = 36'sh000000FFF; 19: v = 36'sh0000007FF; 20: v = 36'sh0000003FF;
            21: v = 36'sh0000001FF; 22: v = 36'sh0000000FF; 23: v = 36'sh00000007F;
            default: v = '0;
        endcase
        return longint'(v);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(tcr_pkg::ANG_PI) : -longint'(tcr_pkg::ANG_PI);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < steps(); i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += arc_tab(i);
            end else begin
                x -= ys; y += xs; z -= arc_tab(i);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_cos(longint a);
        longint x, y, xs, ys;
        x = longint'(tcr_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < steps(); i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (a >= 0) begin
                x -= ys; y += xs; a -= arc_tab(i);
            end else begin
                x += ys; y -= xs; a += arc_tab(i);
            end
        end
        return x;
    endfunction

    function automatic logic signed [15:0] angle_q12(longint a);
        longint r;
        r = fshr(a + (64'sd1 << 17), 18);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic logic [RANGE_BITS:0] predict_altitude();
        longint r, p, tilt, lim, c, alt;
        bit     neg;
        r = roll_q12;
        p = pitch_q12;
        tilt = root64(r * r + p * p) * (64'sd1 << 18);
        lim = (64'sd1 << RANGE_BITS) - 1;
        neg = 0;
        if (tilt > longint'(tcr_pkg::ANG_HALF_PI)) begin
            tilt = longint'(tcr_pkg::ANG_PI) - tilt;
            neg = 1;
        end
        c = rotate_cos(tilt);
        if (neg) c = -c;
        alt = fshr(held_range * c + (64'sd1 << 29), 30);
        if (alt > lim) alt = lim;
        if (alt < -lim) alt = -lim;
        return alt[RANGE_BITS:0];
    endfunction

    task automatic take_quaternion(input logic [79:0] d);
        longint x, y, z, w, sinp, m21, m22, cosp;
        x = longint'($signed(d[31:16]));
        y = longint'($signed(d[47:32]));
        z = longint'($signed(d[63:48]));
        w = longint'($signed(d[79:64]));
        sinp = 2 * (w * y - x * z);
        m21 = 2 * (w * x + y * z);
        m22 = UNIT28 - 2 * (x * x + y * y);
        if (sinp > UNIT28) sinp = UNIT28;
        if (sinp < -UNIT28) sinp = -UNIT28;
        cosp = root64(UNIT28 * UNIT28 - sinp * sinp);
        pitch_q12 = angle_q12(vector_angle(sinp, cosp));
        roll_q12 = angle_q12(vector_angle(m21, m22));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            roll_q12 = 0;
            pitch_q12 = 0;
            held_range = 0;
            have_orient = 0;
            have_range = 0;
            errors = 0;
            altitude_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (altitude_queue.size() == 0) begin
                    $display("%0t: unexpected altitude beat, expected none, actual %h",
                             $time, i_out_data[RANGE_BITS:0]);
                    errors++;
                end else if (altitude_queue[0] !== i_out_data[RANGE_BITS:0]) begin
                    $display("%0t: altitude mismatch, expected %h, actual %h", $time,
                             altitude_queue[0], i_out_data[RANGE_BITS:0]);
                    errors++;
                    void'(altitude_queue.pop_front());
                end else begin
                    void'(altitude_queue.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (!i_in_user) begin
                    held_range = longint'(i_in_data[RANGE_BITS-1:0]);
                    have_range = 1;
                end else begin
                    take_quaternion(i_in_data);
                    have_orient = 1;
                end
                if (have_range && have_orient) altitude_queue.push_back(predict_altitude());
            end
        end
    end

endmodule

FILE: dv/testbench.sv
// Stimulus and verdict for the tilt compensated range unit.
module testbench;

    localparam int LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    int          errors, pending;
    int          cycles = 0;
    bit          calm;

    tilt_compensated_range_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    tcr_scoreboard i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 36);
    end

    function automatic logic [15:0] rand_quat_part();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h0000;
            3: return 16'(int'($urandom));
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic send_beat(input bit kind, input logic [15:0] rng, input logic [15:0] qx,
                             input logic [15:0] qy, input logic [15:0] qz,
                             input logic [15:0] qw);
        while (!calm && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {qw, qz, qy, qx, rng};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_unit_quat();
        logic [15:0] q[4];
        int          i;
        i = $urandom_range(3);
        for (int k = 0; k < 4; k++) q[k] = 16'h0000;
        q[i] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        send_beat(1'b1, 16'($urandom), q[0], q[1], q[2], q[3]);
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tuser = 0;
        s_axis_tdata = '0;
        calm = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed beats: range before any orientation, then extremes and gimbal lock.
        send_beat(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(1'b1, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'sd16384);
        send_beat(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(1'b1, 16'h0000, 16'sd16384, 16'h0000, 16'h0000, 16'h0000);
        send_beat(1'b1, 16'h0000, 16'h0000, 16'sd16384, 16'h0000, 16'h0000);
        send_beat(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'sd16384, 16'h0000);
        send_beat(1'b1, 16'h0000, 16'sd11585, 16'h0000, 16'h0000, 16'sd11585);
        send_beat(1'b1, 16'h0000, 16'h0000, 16'sd11585, 16'h0000, 16'sd11585);
        send_beat(1'b1, 16'h0000, 16'h0000, -16'sd11585, 16'h0000, 16'sd11585);
        send_beat(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(1'b1, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_beat(1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(1'b1, 16'h0000, 16'sd14000, 16'sd14000, 16'h0000, 16'sd3000);
        send_beat(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // Hold off until every expected altitude has come.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < 1150; n++) begin
            calm = (n >= 500 && n < 650);
            case ($urandom_range(9))
                0, 1, 2, 3: send_beat(1'b0, 16'($urandom), rand_quat_part(), rand_quat_part(),
                                      rand_quat_part(), rand_quat_part());
                4: send_unit_quat();
                default: send_beat(1'b1, 16'($urandom), rand_quat_part(), rand_quat_part(),
                                   rand_quat_part(), rand_quat_part());
            endcase
        end
        s_axis_tvalid <= 1'b0;
        calm = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tcr_pkg.sv
sv/tcr_cordic.sv
sv/tcr_isqrt.sv
sv/tilt_compensated_range_unit.sv
sv/tcr_checker.sv
dv/tcr_checker.sv
dv/testbench.sv
